@@ hw/rtl/ctc_greedy_decoder_core_defines.svh @@
// Assertion macros shared by the decoder modules.
`ifndef CTC_GREEDY_DECODER_CORE_DEFINES_SVH
`define CTC_GREEDY_DECODER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CTCGD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CTCGD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

@@ hw/rtl/ctcgd_pkg.sv @@
package ctcgd_pkg;

    // Default sizing of the decoder.
    localparam int MAX_CLASSES_DEF = 8192;
    localparam int MAX_STEPS_DEF   = 256;

    // Score format: unsigned Q1.15, where 32768 stands for 1.0.
    localparam int            SCORE_W   = 16;
    localparam logic [15:0]   SCORE_ONE = 16'd32768;

    // Index of the blank class.
    localparam int BLANK_INDEX = 0;

    // Configuration register widths and reset values.
    localparam int          CFG_CLS_W         = 14;
    localparam int          CFG_STP_W         = 9;
    localparam int          CFG_LBL_W         = 14;
    localparam logic [13:0] NUM_CLASSES_RST   = 14'd6625;
    localparam logic [8:0]  NUM_STEPS_RST     = 9'd40;
    localparam logic [13:0] LABEL_COUNT_RST   = 14'd6625;

    // Configuration port layout.
    localparam int          APB_ADDR_W        = 4;
    localparam int          APB_DATA_W        = 32;
    localparam logic [1:0]  REG_NUM_CLASSES   = 2'd0;
    localparam logic [1:0]  REG_NUM_STEPS     = 2'd1;
    localparam logic [1:0]  REG_LABEL_COUNT   = 2'd2;

    // Result kinds.
    localparam logic        KIND_CHAR         = 1'b0;
    localparam logic        KIND_SUMMARY      = 1'b1;

    // Depth of the event queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Flags of one event passed from the front to the back.
    typedef struct packed {
        logic has_char;
        logic ool;
        logic has_sum;
    } ctcgd_evt_flags_t;

endpackage

@@ hw/rtl/ctcgd_front.sv @@
module ctcgd_front
    import ctcgd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int MAX_STEPS   = MAX_STEPS_DEF,
    parameter int IDX_W       = $clog2(MAX_CLASSES),
    parameter int CNT_W       = $clog2(MAX_STEPS + 1),
    parameter int TOT_W       = CNT_W + SCORE_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SCORE_W-1:0]    s_score_value,
    input  logic [CFG_CLS_W-1:0]  cfg_num_classes,
    input  logic [CFG_STP_W-1:0]  cfg_num_steps,
    input  logic [CFG_LBL_W-1:0]  cfg_label_count,
    output logic                  evt_valid,
    input  logic                  evt_ready,
    output ctcgd_evt_flags_t      evt_flags,
    output logic [IDX_W-1:0]      evt_index,
    output logic [SCORE_W-1:0]    evt_score,
    output logic [CNT_W-1:0]      evt_count,
    output logic [TOT_W-1:0]      evt_total
);

    localparam int STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CMP_W  = (IDX_W + 1 > CFG_CLS_W) ? IDX_W + 1 : CFG_CLS_W;
    localparam int SCMP_W = (STEP_W + 1 > CFG_STP_W) ? STEP_W + 1 : CFG_STP_W;

    logic [SCORE_W-1:0] best_val_reg,   best_val_next;
    logic [IDX_W-1:0]   best_idx_reg,   best_idx_next;
    logic [IDX_W-1:0]   class_pos_reg,  class_pos_next;
    logic [STEP_W-1:0]  step_pos_reg,   step_pos_next;
    logic [IDX_W-1:0]   prev_idx_reg,   prev_idx_next;
    logic [TOT_W-1:0]   total_reg,      total_next;
    logic [CNT_W-1:0]   count_reg,      count_next;

    logic               accept;
    logic [SCORE_W-1:0] score_sat;
    logic               take;
    logic [SCORE_W-1:0] cur_val;
    logic [IDX_W-1:0]   cur_idx;
    logic [CMP_W-1:0]   eff_classes;
    logic [SCMP_W-1:0]  eff_steps;
    logic               row_end;
    logic               seq_end;
    logic               emit_char;
    logic [CNT_W-1:0]   count_after;
    logic [TOT_W-1:0]   total_after;

    // The front stalls only when the event queue is full.
    assign s_ready = evt_ready;
    assign accept  = s_valid && s_ready;

    // Saturate the score and compare it with the running row maximum.
    always_comb begin
        score_sat = (s_score_value > SCORE_ONE) ? SCORE_ONE : s_score_value;
        take      = (class_pos_reg == '0) || (score_sat > best_val_reg);
        cur_val   = take ? score_sat : best_val_reg;
        cur_idx   = take ? class_pos_reg : best_idx_reg;
    end

    // Clamp the row and sequence lengths into their legal range.
    always_comb begin
        if (cfg_num_classes == '0) begin
            eff_classes = CMP_W'(1);
        end else if (CMP_W'(cfg_num_classes) > CMP_W'(MAX_CLASSES)) begin
            eff_classes = CMP_W'(MAX_CLASSES);
        end else begin
            eff_classes = CMP_W'(cfg_num_classes);
        end
        if (cfg_num_steps == '0) begin
            eff_steps = SCMP_W'(1);
        end else if (SCMP_W'(cfg_num_steps) > SCMP_W'(MAX_STEPS)) begin
            eff_steps = SCMP_W'(MAX_STEPS);
        end else begin
            eff_steps = SCMP_W'(cfg_num_steps);
        end
    end

    // Classify the transaction: end of row, character, end of sequence.
    always_comb begin
        row_end   = (CMP_W'(class_pos_reg) + CMP_W'(1)) >= eff_classes;
        seq_end   = row_end && ((SCMP_W'(step_pos_reg) + SCMP_W'(1)) >= eff_steps);
        emit_char = row_end && (cur_idx != IDX_W'(BLANK_INDEX)) &&
                    !((step_pos_reg != '0) && (cur_idx == prev_idx_reg));
        count_after = count_reg + CNT_W'(emit_char);
        total_after = total_reg + (emit_char ? TOT_W'(cur_val) : '0);
    end

    // Event towards the back part.
    always_comb begin
        evt_valid          = accept && (emit_char || seq_end);
        evt_flags.has_char = emit_char;
        evt_flags.ool      = CMP_W'(cur_idx) >= CMP_W'(cfg_label_count);
        evt_flags.has_sum  = seq_end;
        evt_index          = cur_idx;
        evt_score          = cur_val;
        evt_count          = count_after;
        evt_total          = total_after;
    end

    // Next state of the row and sequence tracking.
    always_comb begin
        best_val_next  = best_val_reg;
        best_idx_next  = best_idx_reg;
        class_pos_next = class_pos_reg;
        step_pos_next  = step_pos_reg;
        prev_idx_next  = prev_idx_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        if (accept) begin
            best_val_next  = cur_val;
            best_idx_next  = cur_idx;
            class_pos_next = class_pos_reg + IDX_W'(1);
            if (row_end) begin
                class_pos_next = '0;
                prev_idx_next  = cur_idx;
                step_pos_next  = step_pos_reg + STEP_W'(1);
                total_next     = total_after;
                count_next     = count_after;
            end
            if (seq_end) begin
                best_val_next = '0;
                best_idx_next = '0;
                step_pos_next = '0;
                prev_idx_next = '0;
                total_next    = '0;
                count_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_val_reg  <= '0;
            best_idx_reg  <= '0;
            class_pos_reg <= '0;
            step_pos_reg  <= '0;
            prev_idx_reg  <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
        end else begin
            best_val_reg  <= best_val_next;
            best_idx_reg  <= best_idx_next;
            class_pos_reg <= class_pos_next;
            step_pos_reg  <= step_pos_next;
            prev_idx_reg  <= prev_idx_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
        end
    end

endmodule

@@ hw/rtl/ctcgd_queue.sv @@
`include "ctc_greedy_decoder_core_defines.svh"

module ctcgd_queue
    import ctcgd_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    output logic              full,
    input  logic [DATA_W-1:0] din,
    output logic              not_empty,
    input  logic              pop,
    output logic [DATA_W-1:0] dout
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == QCNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout      = entry_reg[rd_ptr_reg];

    // Pointer and fill level update, wrapping at the queue depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage of the queued events.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    // The front must never push into a full queue.
    `CTCGD_ASSERT_NOW(a_q_no_overflow, aclk, aresetn, push, !full)
    // A push without a pop grows the fill level by exactly one.
    `CTCGD_ASSERT_NEXT(a_q_grow, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ hw/rtl/ctcgd_back.sv @@
`include "ctc_greedy_decoder_core_defines.svh"

module ctcgd_back
    import ctcgd_pkg::*;
#(
    parameter int IDX_W = $clog2(MAX_CLASSES_DEF),
    parameter int CNT_W = $clog2(MAX_STEPS_DEF + 1),
    parameter int TOT_W = CNT_W + SCORE_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  ctcgd_evt_flags_t    q_flags,
    input  logic [IDX_W-1:0]    q_index,
    input  logic [SCORE_W-1:0]  q_score,
    input  logic [CNT_W-1:0]    q_count,
    input  logic [TOT_W-1:0]    q_total,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_result_kind,
    output logic [IDX_W-1:0]    m_class_index,
    output logic [SCORE_W-1:0]  m_char_score,
    output logic                m_out_of_labels,
    output logic [CNT_W-1:0]    m_char_count,
    output logic [SCORE_W-1:0]  m_avg_score,
    output logic                m_empty_result,
    output logic                m_last_of_run
);

    localparam int DCNT_W = $clog2(TOT_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;

    logic [1:0]         state_reg,    state_next;
    logic [DCNT_W-1:0]  div_cnt_reg,  div_cnt_next;
    logic [CNT_W-1:0]   rem_reg,      rem_next;
    logic [TOT_W-1:0]   quo_reg,      quo_next;
    logic [CNT_W-1:0]   divisor_reg,  divisor_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg,  out_kind_next;
    logic [IDX_W-1:0]   out_index_reg, out_index_next;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;
    logic               out_ool_reg,   out_ool_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;
    logic [SCORE_W-1:0] out_avg_reg,   out_avg_next;
    logic               out_empty_reg, out_empty_next;
    logic               out_last_reg,  out_last_next;

    logic               slot_free;
    logic               pop;
    logic [CNT_W:0]     trial;
    logic [CNT_W:0]     diff;
    logic               trial_ge;

    assign slot_free = !out_valid_reg || m_ready;
    assign q_ready   = (state_reg == ST_IDLE) && slot_free;
    assign pop       = q_valid && q_ready;

    // One restoring division step: one quotient bit per cycle.
    always_comb begin
        trial    = {rem_reg, quo_reg[TOT_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        trial_ge = trial >= {1'b0, divisor_reg};
    end

    // Sequencer: emit characters, divide for the summary, emit summaries.
    always_comb begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        divisor_next   = divisor_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_index_next = out_index_reg;
        out_score_next = out_score_reg;
        out_ool_next   = out_ool_reg;
        out_count_next = out_count_reg;
        out_avg_next   = out_avg_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    if (q_flags.has_char) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_CHAR;
                        out_index_next = q_index;
                        out_score_next = q_score;
                        out_ool_next   = q_flags.ool;
                        out_count_next = '0;
                        out_avg_next   = '0;
                        out_empty_next = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    if (q_flags.has_sum) begin
                        rem_next     = '0;
                        quo_next     = q_total;
                        divisor_next = q_count;
                        div_cnt_next = DCNT_W'(TOT_W);
                        state_next   = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                rem_next     = trial_ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                quo_next     = {quo_reg[TOT_W-2:0], trial_ge};
                div_cnt_next = div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == DCNT_W'(1)) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_SUMMARY;
                    out_index_next = '0;
                    out_score_next = '0;
                    out_ool_next   = 1'b0;
                    out_count_next = divisor_reg;
                    out_avg_next   = (divisor_reg == '0) ? '0 : quo_reg[SCORE_W-1:0];
                    out_empty_next = (divisor_reg == '0);
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output payload.
    always_ff @(posedge aclk) begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        divisor_reg   <= divisor_next;
        out_kind_reg  <= out_kind_next;
        out_index_reg <= out_index_next;
        out_score_reg <= out_score_next;
        out_ool_reg   <= out_ool_next;
        out_count_reg <= out_count_next;
        out_avg_reg   <= out_avg_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_kind_reg;
    assign m_class_index   = out_index_reg;
    assign m_char_score    = out_score_reg;
    assign m_out_of_labels = out_ool_reg;
    assign m_char_count    = out_count_reg;
    assign m_avg_score     = out_avg_reg;
    assign m_empty_result  = out_empty_reg;
    assign m_last_of_run   = out_last_reg;

    // The divider always has steps left while it is running.
    `CTCGD_ASSERT_NOW(a_div_cnt_live, aclk, aresetn, state_reg == ST_DIV, div_cnt_reg != '0)
    // A summary is always the last result of its sequence, a character never.
    `CTCGD_ASSERT_NOW(a_last_is_summary, aclk, aresetn, out_valid_reg, out_last_reg == out_kind_reg)
    // An empty summary carries neither a count nor an average.
    `CTCGD_ASSERT_NOW(a_empty_summary, aclk, aresetn, out_valid_reg && out_empty_reg,
                      (out_count_reg == '0) && (out_avg_reg == '0))

endmodule

@@ hw/rtl/ctc_greedy_decoder_core.sv @@
// CTC greedy decoder. Class scores (unsigned Q1.15, values above 1.0 saturate) stream in one
// per transaction, row by row; each row gives its best class (lowest index on a tie), and a
// character result goes out for every row whose best class is neither blank nor a repeat of
// the previous row. After the last row of a sequence a summary result follows with the
// character count and the truncated average score. The front accepts one score per cycle;
// it stalls only when its 4-entry event queue is full. The back loads a character result
// into its output register as it takes the event, so it appears on the next cycle. For each
// summary it divides the TOT_W-bit total (25 bits at default sizing) by the character count
// in its bit-serial divider, taking no events meanwhile, then loads the summary once its
// output register is free; the queue lets the next sequence's scores overlap that divide.
// Registers sit at byte addresses 0 (num_classes), 4 (num_steps) and 8 (label_count) and
// must only be written while the block is idle.
module ctc_greedy_decoder_core
    import ctcgd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF,
    parameter int MAX_STEPS   = MAX_STEPS_DEF,
    parameter int IDX_W       = $clog2(MAX_CLASSES),
    parameter int CNT_W       = $clog2(MAX_STEPS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SCORE_W-1:0]    s_score_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_result_kind,
    output logic [IDX_W-1:0]      m_class_index,
    output logic [SCORE_W-1:0]    m_char_score,
    output logic                  m_out_of_labels,
    output logic [CNT_W-1:0]      m_char_count,
    output logic [SCORE_W-1:0]    m_avg_score,
    output logic                  m_empty_result,
    output logic                  m_last_of_run
);

    localparam int TOT_W = CNT_W + SCORE_W;
    localparam int FLG_W = $bits(ctcgd_evt_flags_t);
    localparam int ENT_W = FLG_W + IDX_W + SCORE_W + CNT_W + TOT_W;

    logic [CFG_CLS_W-1:0] num_classes_reg;
    logic [CFG_STP_W-1:0] num_steps_reg;
    logic [CFG_LBL_W-1:0] label_count_reg;
    logic                 cfg_write;

    logic                 evt_valid;
    logic                 evt_ready;
    ctcgd_evt_flags_t     evt_flags;
    logic [IDX_W-1:0]     evt_index;
    logic [SCORE_W-1:0]   evt_score;
    logic [CNT_W-1:0]     evt_count;
    logic [TOT_W-1:0]     evt_total;

    logic                 q_full;
    logic                 q_valid;
    logic                 q_ready;
    logic [ENT_W-1:0]     q_din;
    logic [ENT_W-1:0]     q_dout;
    ctcgd_evt_flags_t     q_flags;
    logic [IDX_W-1:0]     q_index;
    logic [SCORE_W-1:0]   q_score;
    logic [CNT_W-1:0]     q_count;
    logic [TOT_W-1:0]     q_total;

    // Configuration port: a write lands in the access phase, pready is always high.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_classes_reg <= NUM_CLASSES_RST;
            num_steps_reg   <= NUM_STEPS_RST;
            label_count_reg <= LABEL_COUNT_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_NUM_CLASSES: num_classes_reg <= pwdata[CFG_CLS_W-1:0];
                REG_NUM_STEPS:   num_steps_reg   <= pwdata[CFG_STP_W-1:0];
                REG_LABEL_COUNT: label_count_reg <= pwdata[CFG_LBL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_NUM_CLASSES: prdata = APB_DATA_W'(num_classes_reg);
            REG_NUM_STEPS:   prdata = APB_DATA_W'(num_steps_reg);
            REG_LABEL_COUNT: prdata = APB_DATA_W'(label_count_reg);
            default:         prdata = '0;
        endcase
    end

    // Front part: row maximum, repeat and blank filtering, sequence totals.
    ctcgd_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W),
        .TOT_W       (TOT_W)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_score_value   (s_score_value),
        .cfg_num_classes (num_classes_reg),
        .cfg_num_steps   (num_steps_reg),
        .cfg_label_count (label_count_reg),
        .evt_valid       (evt_valid),
        .evt_ready       (evt_ready),
        .evt_flags       (evt_flags),
        .evt_index       (evt_index),
        .evt_score       (evt_score),
        .evt_count       (evt_count),
        .evt_total       (evt_total)
    );

    // Event queue between the two parts.
    assign evt_ready = !q_full;
    assign q_din     = {evt_flags, evt_index, evt_score, evt_count, evt_total};
    assign {q_flags, q_index, q_score, q_count, q_total} = q_dout;

    ctcgd_queue #(
        .DATA_W (ENT_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (evt_valid),
        .full      (q_full),
        .din       (q_din),
        .not_empty (q_valid),
        .pop       (q_valid && q_ready),
        .dout      (q_dout)
    );

    // Back part: result formatting and the averaging divider.
    ctcgd_back #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W),
        .TOT_W (TOT_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_flags         (q_flags),
        .q_index         (q_index),
        .q_score         (q_score),
        .q_count         (q_count),
        .q_total         (q_total),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_class_index   (m_class_index),
        .m_char_score    (m_char_score),
        .m_out_of_labels (m_out_of_labels),
        .m_char_count    (m_char_count),
        .m_avg_score     (m_avg_score),
        .m_empty_result  (m_empty_result),
        .m_last_of_run   (m_last_of_run)
    );

endmodule
